// File: hdl/isap_rk_pkg.sv
// ----------------------------------------------------------------------------
// isap_rk_pkg
// Shared types, constants and helpers for the ISAP rekeying block.
// ----------------------------------------------------------------------------
package isap_rk_pkg;

    localparam int WORD_W    = 64;
    localparam int NUM_WORDS = 5;
    localparam int NUM_BYTES = NUM_WORDS * WORD_W / 8;
    localparam int MAX_RND   = 12;
    localparam int RND_W     = 4;
    localparam int LEN_W     = 6;
    localparam int IDX_W     = 3;

    // configuration register indexes
    localparam logic [IDX_W-1:0] REG_KEY_HIGH   = 3'd0;
    localparam logic [IDX_W-1:0] REG_KEY_LOW    = 3'd1;
    localparam logic [IDX_W-1:0] REG_INIT_VEC   = 3'd2;
    localparam logic [IDX_W-1:0] REG_BIT_ROUNDS = 3'd3;
    localparam logic [IDX_W-1:0] REG_KEY_ROUNDS = 3'd4;
    localparam logic [IDX_W-1:0] REG_OUT_LENGTH = 3'd5;

    typedef logic [WORD_W-1:0]             t_word;
    typedef logic [NUM_WORDS-1:0][WORD_W-1:0] t_state;
    typedef logic [RND_W-1:0]              t_rnd;

    function automatic t_word rotr(input t_word x, input int n);
        rotr = (x >> n) | (x << (WORD_W - n));
    endfunction

    // first round index of a permutation of cnt rounds (last cnt of 12)
    function automatic t_rnd rnd_start(input t_rnd cnt);
        if (cnt >= RND_W'(MAX_RND)) begin
            rnd_start = '0;
        end else begin
            rnd_start = RND_W'(MAX_RND) - cnt;
        end
    endfunction

endpackage

// File: hdl/isap_rk_in_if.sv
// ----------------------------------------------------------------------------
// isap_rk_in_if
// Message byte channel: valid/ready with one byte and a last flag.
// ----------------------------------------------------------------------------
interface isap_rk_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// File: hdl/isap_rk_out_if.sv
// ----------------------------------------------------------------------------
// isap_rk_out_if
// Derived key channel: valid/ready with five 64-bit state words.
// ----------------------------------------------------------------------------
interface isap_rk_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] word_zero;
    logic [63:0] word_one;
    logic [63:0] word_two;
    logic [63:0] word_three;
    logic [63:0] word_four;

    modport source (output valid, output word_zero, output word_one, output word_two,
                    output word_three, output word_four, input ready);
    modport sink   (input valid, input word_zero, input word_one, input word_two,
                    input word_three, input word_four, output ready);
endinterface

// File: hdl/isap_rk_round.sv
// ----------------------------------------------------------------------------
// isap_rk_round
// One Ascon permutation round: constant add, s-box layer, linear layer.
// ----------------------------------------------------------------------------
module isap_rk_round (
    input  isap_rk_pkg::t_state i_state,
    input  isap_rk_pkg::t_rnd   i_rnd,
    output isap_rk_pkg::t_state o_state
);
    import isap_rk_pkg::*;

    t_word a, b, c, d, e;
    t_word na, nb, nc, nd, ne;

    always_comb begin
        a = i_state[0];
        b = i_state[1];
        c = i_state[2] ^ {56'd0, 4'hF - i_rnd, i_rnd};
        d = i_state[3];
        e = i_state[4];
        a = a ^ e;
        e = e ^ d;
        c = c ^ b;
        na = a ^ (~b & c);
        nb = b ^ (~c & d);
        nc = c ^ (~d & e);
        nd = d ^ (~e & a);
        ne = e ^ (~a & b);
        nb = nb ^ na;
        na = na ^ ne;
        nd = nd ^ nc;
        nc = ~nc;
        o_state[0] = na ^ rotr(na, 19) ^ rotr(na, 28);
        o_state[1] = nb ^ rotr(nb, 61) ^ rotr(nb, 39);
        o_state[2] = nc ^ rotr(nc, 1)  ^ rotr(nc, 6);
        o_state[3] = nd ^ rotr(nd, 10) ^ rotr(nd, 17);
        o_state[4] = ne ^ rotr(ne, 7)  ^ rotr(ne, 41);
    end

endmodule

// File: hdl/isap_rk_absorb.sv
// ----------------------------------------------------------------------------
// isap_rk_absorb
// Bit injection: XOR of the current message bit into the top of word 0.
// ----------------------------------------------------------------------------
module isap_rk_absorb (
    input  isap_rk_pkg::t_state i_state,
    input  logic [7:0]          i_byte,
    input  logic [2:0]          i_bit,
    output isap_rk_pkg::t_state o_state
);
    import isap_rk_pkg::*;

    always_comb begin
        o_state = i_state;
        o_state[0][WORD_W-1] = i_state[0][WORD_W-1] ^ i_byte[i_bit];
    end

endmodule

// File: hdl/isap_rk_ascon.sv
// ----------------------------------------------------------------------------
// isap_rekey_ascon
// ISAP rekeying over the Ascon-p permutation, one round per cycle.
//
//   channel   | dir | handshake          | payload
//   ----------+-----+--------------------+-------------------------------------
//   i_data    | in  | valid/ready        | data_byte[7:0], last_byte
//   o_res     | out | valid/ready        | word_zero..word_four, 64 bits each
//   i_cfg_*   | in  | write enable only  | index[2:0], data[63:0]
//
// Per byte: take it in idle, then inject each of its eight bits and run
// bit_rounds rounds after each; a message's first byte is preceded by
// key_rounds key-load rounds, its last bit gets key_rounds instead, and the
// result register is loaded last. The single round unit runs once per cycle.
// Reset: synchronous, active low; all but the byte, last and output registers
// return to reset values and the block waits for the first byte of a message.
// Stalls: a result waits in the output register; the next message is
// taken meanwhile and only blocks at its own result if that is still held.
// ----------------------------------------------------------------------------
module isap_rekey_ascon (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    isap_rk_in_if.sink                     i_data,
    isap_rk_out_if.source                  o_res,
    input  logic                           i_cfg_we,
    input  logic [isap_rk_pkg::IDX_W-1:0]  i_cfg_idx,
    input  logic [isap_rk_pkg::WORD_W-1:0] i_cfg_data
);
    import isap_rk_pkg::*;

    // sequencer codes
    localparam logic [1:0] ST_IDLE   = 2'd0;  // waiting for a byte
    localparam logic [1:0] ST_ABSORB = 2'd1;  // inject one bit, pick round count
    localparam logic [1:0] ST_PERM   = 2'd2;  // one round per cycle
    localparam logic [1:0] ST_DONE   = 2'd3;  // load output register

    // configuration
    t_word              r_key_high, r_key_low, r_init_vec;
    t_rnd               r_bit_rounds, r_key_rounds;
    logic [LEN_W-1:0]   r_out_len;

    // control
    logic [1:0] r_st, n_st;
    t_rnd       r_rnd, n_rnd;
    logic [2:0] r_bit, n_bit;
    logic       r_init, n_init;     // running the initial key permutation
    logic       r_fresh, n_fresh;   // next byte starts a new message
    logic       r_out_valid, n_out_valid;

    // payload
    logic [7:0] r_byte;
    logic       r_last;
    t_state     r_state, n_state;
    t_state     r_out, n_out;

    t_state     w_round;
    t_state     w_absorbed;
    logic       w_in_acc;
    logic       w_out_free;

    isap_rk_round u_round (
        .i_state (r_state),
        .i_rnd   (r_rnd),
        .o_state (w_round)
    );

    isap_rk_absorb u_absorb (
        .i_state (r_state),
        .i_byte  (r_byte),
        .i_bit   (r_bit),
        .o_state (w_absorbed)
    );

    // no item is taken while reset is held
    assign i_data.ready = i_rst_n && (r_st == ST_IDLE);
    assign w_in_acc     = i_data.valid && i_data.ready;
    assign w_out_free   = !r_out_valid || o_res.ready;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high   <= '0;
            r_key_low    <= '0;
            r_init_vec   <= '0;
            r_bit_rounds <= RND_W'(1);
            r_key_rounds <= RND_W'(MAX_RND);
            r_out_len    <= LEN_W'(24);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_KEY_HIGH:   r_key_high   <= i_cfg_data;
                REG_KEY_LOW:    r_key_low    <= i_cfg_data;
                REG_INIT_VEC:   r_init_vec   <= i_cfg_data;
                REG_BIT_ROUNDS: r_bit_rounds <= i_cfg_data[RND_W-1:0];
                REG_KEY_ROUNDS: r_key_rounds <= i_cfg_data[RND_W-1:0];
                REG_OUT_LENGTH: r_out_len    <= i_cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // output mask: byte k of the state (k = 8*w + b) survives when k < out_length
    always_comb begin
        for (int w = 0; w < NUM_WORDS; w++) begin
            for (int b = 0; b < 8; b++) begin
                n_out[w][WORD_W-1-8*b -: 8] =
                    (LEN_W'(8*w + b) < r_out_len) ? r_state[w][WORD_W-1-8*b -: 8] : 8'd0;
            end
        end
    end

    // sequencer
    always_comb begin
        n_st        = r_st;
        n_rnd       = r_rnd;
        n_bit       = r_bit;
        n_init      = r_init;
        n_fresh     = r_fresh;
        n_state     = r_state;
        n_out_valid = r_out_valid;
        if (r_out_valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_st)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_bit   = 3'd7;
                    n_fresh = 1'b0;
                    if (r_fresh) begin
                        n_state = {64'd0, 64'd0, r_init_vec, r_key_low, r_key_high};
                        n_rnd   = rnd_start(r_key_rounds);
                        n_init  = 1'b1;
                        n_st    = ST_PERM;
                    end else begin
                        n_st    = ST_ABSORB;
                    end
                end
            end
            ST_ABSORB: begin
                n_state = w_absorbed;
                // the final bit of a message gets the key-round count
                n_rnd   = (r_bit == 3'd0 && r_last) ? rnd_start(r_key_rounds)
                                                    : rnd_start(r_bit_rounds);
                n_st    = ST_PERM;
            end
            ST_PERM: begin
                if (r_rnd == RND_W'(MAX_RND)) begin
                    if (r_init) begin
                        n_init = 1'b0;
                        n_st   = ST_ABSORB;
                    end else if (r_bit != 3'd0) begin
                        n_bit  = r_bit - 3'd1;
                        n_st   = ST_ABSORB;
                    end else if (r_last) begin
                        n_st   = ST_DONE;
                    end else begin
                        n_st   = ST_IDLE;
                    end
                end else begin
                    n_state = w_round;
                    n_rnd   = r_rnd + RND_W'(1);
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_fresh     = 1'b1;
                    n_st        = ST_IDLE;
                end
            end
            default: n_st = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= ST_IDLE;
            r_rnd       <= '0;
            r_bit       <= '0;
            r_init      <= 1'b0;
            r_fresh     <= 1'b1;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            r_st        <= n_st;
            r_rnd       <= n_rnd;
            r_bit       <= n_bit;
            r_init      <= n_init;
            r_fresh     <= n_fresh;
            r_out_valid <= n_out_valid;
            r_state     <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_byte <= i_data.data_byte;
            r_last <= i_data.last_byte;
        end
        if (r_st == ST_DONE && w_out_free) begin
            r_out <= n_out;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.word_zero  = r_out[0];
    assign o_res.word_one   = r_out[1];
    assign o_res.word_two   = r_out[2];
    assign o_res.word_three = r_out[3];
    assign o_res.word_four  = r_out[4];

    // round index never runs past the end of the schedule
    a_rnd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rnd <= RND_W'(MAX_RND))
        else $error("round index out of range");

    // the key-load permutation only exists while rounds are running
    a_init_perm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_init |-> (r_st == ST_PERM))
        else $error("init flag outside permutation");

    // delivering a result re-arms the key load for the next message
    a_fresh_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_DONE && w_out_free) |=> (r_fresh && r_out_valid))
        else $error("result not registered or message not re-armed");

    // a held result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_DONE && r_out_valid && !o_res.ready) |=> (r_st == ST_DONE))
        else $error("result overwritten while held");

endmodule

// File: bench/isap_rekey_ascon_checker.sv
// ============================================================================
// isap_rekey_ascon_checker
// Watches the byte and key channels and the register port, keeps its own
// Ascon rekeying state, and checks each derived key against the prediction.
// ============================================================================
module isap_rekey_ascon_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    isap_rk_in_if                          i_msg,
    isap_rk_out_if                         i_key,
    input  logic                           i_cfg_we,
    input  logic [isap_rk_pkg::IDX_W-1:0]  i_cfg_idx,
    input  logic [isap_rk_pkg::WORD_W-1:0] i_cfg_data,
    output int                             o_fail_count,
    output int                             o_pending,
    output int                             o_keys_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    import isap_rk_pkg::*;

    // register copies
    t_word            key_hi;
    t_word            key_lo;
    t_word            iv_word;
    t_rnd             bit_rnd;
    t_rnd             key_rnd;
    logic [LEN_W-1:0] out_len;

    // permutation state
    t_word            lane [NUM_WORDS];
    logic             awaiting_first;

    t_state           derived_q [$];
    int               fails = 0;
    int               seen = 0;
    string            word_names [NUM_WORDS] =
        '{"word_zero", "word_one", "word_two", "word_three", "word_four"};

    function automatic t_word ror(input t_word x, input int n);
        logic [2*WORD_W-1:0] twice;
        twice = {x, x} >> n;
        return twice[WORD_W-1:0];
    endfunction

    // last `count` of the twelve rounds, saturating at twelve
    function automatic void ascon_rounds(input t_rnd count);
        t_word a, b, c, d, e;
        t_word ta, tb, tc, td, te;
        int    n;
        n = (count > t_rnd'(MAX_RND)) ? MAX_RND : int'(count);
        a = lane[0]; b = lane[1]; c = lane[2]; d = lane[3]; e = lane[4];
        for (int r = MAX_RND - n; r < MAX_RND; r++) begin
            c ^= t_word'(((15 - r) << 4) | r);
            a ^= e; e ^= d; c ^= b;
            ta = a ^ (~b & c);
            tb = b ^ (~c & d);
            tc = c ^ (~d & e);
            td = d ^ (~e & a);
            te = e ^ (~a & b);
            tb ^= ta; ta ^= te; td ^= tc; tc = ~tc;
            a = ta ^ ror(ta, 19) ^ ror(ta, 28);
            b = tb ^ ror(tb, 61) ^ ror(tb, 39);
            c = tc ^ ror(tc, 1)  ^ ror(tc, 6);
            d = td ^ ror(td, 10) ^ ror(td, 17);
            e = te ^ ror(te, 7)  ^ ror(te, 41);
        end
        lane[0] = a; lane[1] = b; lane[2] = c; lane[3] = d; lane[4] = e;
    endfunction

    function automatic void absorb_byte(input logic [7:0] b, input logic fin);
        t_state key;
        int     len;
        if (awaiting_first) begin
            lane[0] = key_hi;
            lane[1] = key_lo;
            lane[2] = iv_word;
            lane[3] = '0;
            lane[4] = '0;
            ascon_rounds(key_rnd);
            awaiting_first = 1'b0;
        end
        for (int k = 7; k >= 0; k--) begin
            lane[0][WORD_W-1] ^= b[k];
            ascon_rounds((k == 0 && fin) ? key_rnd : bit_rnd);
        end
        if (fin) begin
            key = '0;
            len = (out_len > LEN_W'(NUM_BYTES)) ? NUM_BYTES : int'(out_len);
            for (int i = 0; i < NUM_BYTES; i++) begin
                if (i < len) begin
                    key[i / 8][63 - 8 * (i % 8) -: 8] = lane[i / 8][63 - 8 * (i % 8) -: 8];
                end
            end
            derived_q.push_back(key);
            awaiting_first = 1'b1;
        end
    endfunction

    always @(posedge i_clk) begin
        t_state got;
        t_state want;
        if (!i_rst_n) begin
            key_hi         = '0;
            key_lo         = '0;
            iv_word        = '0;
            bit_rnd        = t_rnd'(1);
            key_rnd        = t_rnd'(MAX_RND);
            out_len        = LEN_W'(24);
            awaiting_first = 1'b1;
            for (int w = 0; w < NUM_WORDS; w++) begin
                lane[w] = '0;
            end
            derived_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_KEY_HIGH:   key_hi  = i_cfg_data;
                    REG_KEY_LOW:    key_lo  = i_cfg_data;
                    REG_INIT_VEC:   iv_word = i_cfg_data;
                    REG_BIT_ROUNDS: bit_rnd = i_cfg_data[RND_W-1:0];
                    REG_KEY_ROUNDS: key_rnd = i_cfg_data[RND_W-1:0];
                    REG_OUT_LENGTH: out_len = i_cfg_data[LEN_W-1:0];
                    default: ;
                endcase
            end
            if (i_key.valid && i_key.ready) begin
                got = {i_key.word_four, i_key.word_three, i_key.word_two,
                       i_key.word_one, i_key.word_zero};
                if (derived_q.size() == 0) begin
                    fails++;
                    $display("%0t: derived key with none expected, expected nothing actual %h",
                             $time, got);
                end else begin
                    want = derived_q.pop_front();
                    seen++;
                    for (int w = 0; w < NUM_WORDS; w++) begin
                        if (got[w] !== want[w]) begin
                            fails++;
                            $display("%0t: %s mismatch, expected %h actual %h",
                                     $time, word_names[w], want[w], got[w]);
                        end
                    end
                end
            end
            if (i_msg.valid && i_msg.ready) begin
                absorb_byte(i_msg.data_byte, i_msg.last_byte);
            end
        end
        o_fail_count <= fails;
        o_pending    <= derived_q.size();
        o_keys_seen  <= seen;
    end

endmodule

// File: bench/isap_rekey_ascon_tb.sv
// ============================================================================
// isap_rekey_ascon_tb
// Drives messages into the ISAP rekeying block under a series of key, IV,
// round-count and output-length settings, with random gaps and stalls on
// both channels; the checker beside the block predicts every derived key.
// ============================================================================
module isap_rekey_ascon_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import isap_rk_pkg::*;

    localparam int CLK_HALF        = 5;
    localparam int RESET_CYCLES    = 7;
    localparam int SETTLE_CYCLES   = 150;
    localparam int TAIL_CYCLES     = 300;
    // long receiver hold-off used to back the block up
    localparam int RX_HOLD_CYCLES  = 1000;
    // several times the longest quiet stretch of a correct run
    localparam int WATCHDOG_LIMIT  = 6000;
    localparam int TARGET_BYTES    = 1800;
    localparam int BYTES_PER_PHASE = 150;
    localparam int PRESSURE_PHASE  = 3;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              cfg_we;
    logic [IDX_W-1:0]  cfg_idx;
    logic [WORD_W-1:0] cfg_data;

    isap_rk_in_if  msg_ch ();
    isap_rk_out_if key_ch ();

    int fail_count;
    int pending;
    int keys_seen;
    int hold_reqs;
    int quiet_cycles = 0;
    int bytes_sent = 0;
    int msgs_sent = 0;
    int settings = 1;

    always #(CLK_HALF) i_clk = ~i_clk;

    isap_rekey_ascon DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_data     (msg_ch),
        .o_res      (key_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    isap_rekey_ascon_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_msg        (msg_ch),
        .i_key        (key_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_keys_seen  (keys_seen)
    );

    // ------------------------------------------------------------------------
    // Key receiver. Mostly ready with short stalls, now and then a calm
    // stretch with no stalls or a longer stall. A hold request from the
    // stimulus side drops ready for RX_HOLD_CYCLES so the block backs up.
    // ------------------------------------------------------------------------
    initial begin
        int roll;
        int calm_left;
        int holds_done;
        calm_left  = 0;
        holds_done = 0;
        key_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_reqs != holds_done) begin
                holds_done++;
                key_ch.ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge i_clk);
                key_ch.ready <= 1'b1;
            end else if (calm_left > 0) begin
                calm_left--;
                key_ch.ready <= 1'b1;
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < 10) begin
                    calm_left = $urandom_range(20, 200);
                    key_ch.ready <= 1'b1;
                end else if (roll < 65) begin
                    key_ch.ready <= 1'b1;
                end else if (roll < 95) begin
                    key_ch.ready <= 1'b0;
                end else begin
                    key_ch.ready <= 1'b0;
                    repeat ($urandom_range(10, 60)) @(posedge i_clk);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: any handshake or register write counts as progress.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n || cfg_we || (msg_ch.valid && msg_ch.ready)
                || (key_ch.valid && key_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("Verification failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Offer one byte after `gap` idle cycles and return in the step of its
    // handshake, valid still high; the next call or a drain lowers it.
    task automatic send_byte(input logic [7:0] b, input logic fin, input int gap);
        if (gap > 0) begin
            msg_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        msg_ch.valid     <= 1'b1;
        msg_ch.data_byte <= b;
        msg_ch.last_byte <= fin;
        do @(posedge i_clk); while (!msg_ch.ready);
        bytes_sent++;
        if (fin) msgs_sent++;
    endtask

    // Sender pause: stop offering, wait for every key to come out, then let
    // the block settle. Only called after a last byte.
    task automatic drain();
        msg_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [WORD_W-1:0] value);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(posedge i_clk);
    endtask

    // Registers only change with the block idle.
    task automatic program_regs(input t_word kh, input t_word kl, input t_word iv,
                                input t_rnd br, input t_rnd kr,
                                input logic [LEN_W-1:0] ol);
        drain();
        write_reg(REG_KEY_HIGH, kh);
        write_reg(REG_KEY_LOW, kl);
        write_reg(REG_INIT_VEC, iv);
        write_reg(REG_BIT_ROUNDS, WORD_W'(br));
        write_reg(REG_KEY_ROUNDS, WORD_W'(kr));
        write_reg(REG_OUT_LENGTH, WORD_W'(ol));
        cfg_we <= 1'b0;
        settings++;
    endtask

    // mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic t_word pick_word();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) return '0;
        if (roll == 1) return '1;
        return {$urandom, $urandom};
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int          phase;
        int          phase_start;
        int          msg_len;
        int          roll;
        logic        steady;
        logic [7:0]  b;
        t_rnd        br;

        i_rst_n          <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_idx          <= '0;
        cfg_data         <= '0;
        msg_ch.valid     <= 1'b0;
        msg_ch.data_byte <= '0;
        msg_ch.last_byte <= 1'b0;
        hold_reqs        <= 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // --- directed part ---------------------------------------------------
        // reset settings: all-zero key and IV, one round per bit, 24 bytes out
        send_byte(8'h00, 1'b1, 0);
        send_byte(8'hFF, 1'b1, 0);
        send_byte(8'h80, 1'b0, 0);
        send_byte(8'h01, 1'b0, 2);
        send_byte(8'hFF, 1'b1, 0);

        // no rounds per bit, oversized key-round count, empty output
        program_regs(64'h0123456789abcdef, 64'hfedcba9876543210, 64'h01800c0100000000,
                     t_rnd'(0), t_rnd'(15), LEN_W'(0));
        send_byte(8'hA5, 1'b1, 0);
        send_byte(8'h3C, 1'b0, 0);
        send_byte(8'hC3, 1'b1, 1);

        // all-ones key and IV, full rounds per bit, one key round, full output
        program_regs('1, '1, '1, t_rnd'(MAX_RND), t_rnd'(1), LEN_W'(NUM_BYTES));
        send_byte(8'h5A, 1'b0, 0);
        send_byte(8'hC3, 1'b1, 0);

        // oversized bit rounds, no key rounds, output length past the state
        program_regs('0, '0, '0, t_rnd'(15), t_rnd'(0), LEN_W'(63));
        send_byte(8'h0F, 1'b1, 0);
        send_byte(8'hF0, 1'b1, 0);

        // a single output byte
        program_regs({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                     t_rnd'(1), t_rnd'(MAX_RND), LEN_W'(1));
        send_byte(8'h7F, 1'b0, 0);
        send_byte(8'h55, 1'b1, 0);
        send_byte(8'hAA, 1'b1, 0);

        // just past the limits: 13 key rounds, 41 output bytes
        program_regs({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                     t_rnd'(2), t_rnd'(13), LEN_W'(41));
        send_byte(8'h01, 1'b1, 0);

        // --- random part -----------------------------------------------------
        phase = 0;
        while (bytes_sent < TARGET_BYTES) begin
            // keep bit rounds mostly small so the run stays short
            roll = $urandom_range(0, 99);
            if (roll < 70) br = t_rnd'($urandom_range(1, 3));
            else if (roll < 85) br = t_rnd'($urandom_range(4, MAX_RND));
            else br = t_rnd'($urandom_range(0, 15));
            program_regs(pick_word(), pick_word(), pick_word(), br,
                         t_rnd'($urandom_range(0, 15)),
                         ($urandom_range(0, 9) < 7) ? LEN_W'($urandom_range(1, NUM_BYTES))
                                                   : LEN_W'($urandom_range(0, 63)));
            steady      = ($urandom_range(0, 3) == 0);
            phase_start = bytes_sent;

            // back the block up: the receiver stops while short messages
            // keep coming with no gaps
            if (phase == PRESSURE_PHASE) begin
                hold_reqs <= hold_reqs + 1;
                repeat (24) begin
                    send_byte(8'($urandom), 1'b1, 0);
                end
            end

            while (bytes_sent - phase_start < BYTES_PER_PHASE) begin
                roll = $urandom_range(0, 99);
                if (roll < 70) msg_len = $urandom_range(1, 3);
                else if (roll < 95) msg_len = $urandom_range(4, 10);
                else msg_len = $urandom_range(11, 32);
                for (int i = 0; i < msg_len; i++) begin
                    roll = $urandom_range(0, 19);
                    if (roll == 0) b = 8'h00;
                    else if (roll == 1) b = 8'hFF;
                    else b = 8'($urandom);
                    send_byte(b, (i == msg_len - 1), steady ? 0 : pick_gap());
                end
            end
            phase++;
        end

        // --- wrap-up ---------------------------------------------------------
        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Run covered %0d message bytes in %0d messages over %0d register settings,",
                 bytes_sent, msgs_sent, settings);
        $display("with %0d derived keys compared and %0d mismatches.", keys_seen, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
